[src/art_pkg.sv]
// Shared types and constants for the ACK retransmit tracker.
// Depends on nothing; every other file but art_ram imports it.
package art_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = 5;
    localparam int MAX_PAYLOAD = 100;
    localparam logic [6:0] HEADER_BYTES = 7'd3;
    localparam logic [7:0] TYPE_DATA = 8'd68;
    localparam logic [7:0] TYPE_ACK  = 8'd65;
    localparam logic [31:0] AGE_RESET = 32'd3000000;

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_SENT       = 3'd0,
        KIND_TABLE_FULL = 3'd1,
        KIND_ACK_OUT    = 3'd2,
        KIND_EMPTY      = 3'd3,
        KIND_ACK_CLEAR  = 3'd4,
        KIND_ACK_MISS   = 3'd5,
        KIND_BAD_FRAME  = 3'd6,
        KIND_RESEND     = 3'd7
    } kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now;
        logic [6:0]  payload_len;
        logic [15:0] peer;
        logic [7:0]  send_flags;
        logic [7:0]  frame_type;
        logic [15:0] frame_id;
        logic        frame_empty;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] msg_id;
        logic [4:0]  slot;
        logic [6:0]  frame_len;
        logic [15:0] peer_out;
        logic [7:0]  flags_out;
        logic [31:0] transmissions;
        logic [5:0]  outstanding;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] stamp;
        logic [6:0]  len;
        logic [15:0] peer;
        logic [7:0]  flags;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/art_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// Standalone; no package needed.
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[src/art_out_reg.sv]
// Output register of the tracker: holds one result until the sink takes it.
// Depends on art_pkg.
module art_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  art_pkg::out_item_t load_data,
    input  logic              stall,
    output logic              valid,
    output art_pkg::out_item_t data,
    output logic              free
);
    import art_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

[src/ack_retransmit_tracker_top.sv]
// ACK retransmit tracker: table of sent, unacknowledged messages in one RAM.
// Send and plain frames give their result from the single-result state.
// ACK match and tick walk the table one slot at a time (RAM read, then
// evaluate); an ACK stops at its match, a miss or a tick ends after the last slot.
// Throughput: one item at a time; the next item is taken once the tracker is
// idle again, after its last result is loaded; output stalls hold it there.
// Reset (rst_n, async low): all slots invalid, id/counters zero, age 3000000.
// Entry RAM contents are undefined after reset; only data of valid slots is used.
module ack_retransmit_tracker_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  art_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output art_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import art_pkg::*;

    // One-hot sequencer: single result, RAM read, evaluate, final flush.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SINGLE = 5'b00010,
        ST_RD     = 5'b00100,
        ST_EV     = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    in_item_t               item_reg;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [15:0]            next_id_reg, next_id_next;
    logic [31:0]            tx_reg, tx_next;
    logic [5:0]             pend_reg, pend_next;
    logic [31:0]            age_reg;
    logic                   hold_valid_reg, hold_valid_next;
    out_item_t              hold_reg, hold_next;

    logic              emit;
    out_item_t         emit_data;
    logic              out_free;
    logic              ram_wr_en, ram_rd_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_raw;
    entry_t            ent;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [6:0]        plen_sat;
    logic [6:0]        flen;
    logic [31:0]       age;
    logic              last_idx;
    logic              accept;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign ent        = entry_t'(ram_rd_raw);
    assign age        = item_reg.now - ent.stamp;
    assign last_idx   = (idx_reg == SLOT_W'(TABLE_DEPTH - 1));

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Saturate payload, add header bytes.
    always_comb
    begin
        plen_sat = (32'(item_reg.payload_len) > 32'(MAX_PAYLOAD)) ?
                   7'(MAX_PAYLOAD) : item_reg.payload_len;
        flen     = plen_sat + HEADER_BYTES;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        next_id_next    = next_id_reg;
        tx_next         = tx_reg;
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        emit            = 1'b0;
        emit_data       = '0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ent;
        ram_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    case (cmd_t'(item.command))
                        CMD_SEND:  state_next = ST_SINGLE;
                        CMD_FRAME:
                        begin
                            if (!item.frame_empty && item.frame_type == TYPE_ACK)
                            begin
                                state_next = ST_RD;
                            end
                            else
                            begin
                                state_next = ST_SINGLE;
                            end
                        end
                        CMD_TICK:  state_next = ST_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SINGLE:
            begin
                // Send, plain frame, or an ACK whose walk found no match.
                emit_data.msg_id   = item_reg.frame_id;
                emit_data.peer_out = item_reg.peer;
                emit_data.last     = 1'b1;
                if (item_reg.command == CMD_SEND)
                begin
                    emit_data.msg_id    = next_id_reg;
                    emit_data.frame_len = flen;
                    emit_data.flags_out = item_reg.send_flags;
                    emit_data.transmissions = tx_reg + 32'd1;
                    if (free_found)
                    begin
                        emit_data.kind        = KIND_SENT;
                        emit_data.slot        = free_idx;
                        emit_data.outstanding = pend_reg + 6'd1;
                    end
                    else
                    begin
                        emit_data.kind        = KIND_TABLE_FULL;
                        emit_data.outstanding = pend_reg;
                    end
                end
                else
                begin
                    emit_data.transmissions = tx_reg;
                    emit_data.outstanding   = pend_reg;
                    if (item_reg.frame_empty)
                    begin
                        emit_data.kind = KIND_EMPTY;
                    end
                    else if (item_reg.frame_type == TYPE_DATA)
                    begin
                        emit_data.kind = KIND_ACK_OUT;
                    end
                    else if (item_reg.frame_type == TYPE_ACK)
                    begin
                        emit_data.kind = KIND_ACK_MISS;
                    end
                    else
                    begin
                        emit_data.kind = KIND_BAD_FRAME;
                    end
                end

                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (item_reg.command == CMD_SEND)
                    begin
                        next_id_next = next_id_reg + 16'd1;
                        tx_next      = tx_reg + 32'd1;
                        if (free_found)
                        begin
                            valid_next[free_idx]  = 1'b1;
                            pend_next             = pend_reg + 6'd1;
                            ram_wr_en             = 1'b1;
                            ram_wr_addr           = free_idx;
                            ram_wr_data.id        = next_id_reg;
                            ram_wr_data.stamp     = item_reg.now;
                            ram_wr_data.len       = flen;
                            ram_wr_data.peer      = item_reg.peer;
                            ram_wr_data.flags     = item_reg.send_flags;
                        end
                    end
                end
            end

            ST_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_EV;
            end

            ST_EV:
            begin
                // RAM data holds while waiting here: no read is issued.
                if (item_reg.command == CMD_TICK)
                begin
                    if (valid_reg[idx_reg] && age >= age_reg)
                    begin
                        if (!hold_valid_reg || out_free)
                        begin
                            emit      = hold_valid_reg;
                            emit_data = hold_reg;
                            emit_data.last = 1'b0;
                            ram_wr_en = 1'b1;
                            ram_wr_data.stamp = item_reg.now;
                            tx_next   = tx_reg + 32'd1;
                            hold_valid_next         = 1'b1;
                            hold_next.kind          = KIND_RESEND;
                            hold_next.msg_id        = ent.id;
                            hold_next.slot          = idx_reg;
                            hold_next.frame_len     = ent.len;
                            hold_next.peer_out      = ent.peer;
                            hold_next.flags_out     = ent.flags;
                            hold_next.transmissions = tx_reg + 32'd1;
                            hold_next.outstanding   = pend_reg;
                            hold_next.last          = 1'b1;
                            state_next = last_idx ? ST_FLUSH : ST_RD;
                            idx_next   = idx_reg + SLOT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next = last_idx ? ST_FLUSH : ST_RD;
                        idx_next   = idx_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    if (valid_reg[idx_reg] && ent.id == item_reg.frame_id)
                    begin
                        emit_data.kind          = KIND_ACK_CLEAR;
                        emit_data.msg_id        = item_reg.frame_id;
                        emit_data.slot          = idx_reg;
                        emit_data.frame_len     = ent.len;
                        emit_data.peer_out      = ent.peer;
                        emit_data.flags_out     = ent.flags;
                        emit_data.transmissions = tx_reg;
                        emit_data.outstanding   = pend_reg - 6'd1;
                        emit_data.last          = 1'b1;
                        if (out_free)
                        begin
                            emit                = 1'b1;
                            valid_next[idx_reg] = 1'b0;
                            pend_next           = pend_reg - 6'd1;
                            state_next          = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = last_idx ? ST_SINGLE : ST_RD;
                        idx_next   = idx_reg + SLOT_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                // Release the final resend with its last mark set.
                emit_data = hold_reg;
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit            = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            next_id_reg    <= '0;
            tx_reg         <= '0;
            pend_reg       <= '0;
            hold_valid_reg <= 1'b0;
            age_reg        <= AGE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            next_id_reg    <= next_id_next;
            tx_reg         <= tx_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                age_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold the accepted item and the pending resend.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        hold_reg <= hold_next;
    end

    art_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_raw)
    );

    art_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (emit_data),
        .stall     (result_stall),
        .valid     (result_valid),
        .data      (result),
        .free      (out_free)
    );
endmodule

[src/art_checker.sv]
// Port-level checks for the tracker, bound onto the top level.
// Depends on art_pkg and ack_retransmit_tracker_top.
module art_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input art_pkg::in_item_t  item,
    input logic               result_valid,
    input logic               result_stall,
    input art_pkg::out_item_t result,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [31:0]        cfg_data
);
    import art_pkg::*;

    // A stalled result transfer holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // One item at a time: an accepted item with a known command closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.command != CMD_NONE |=> item_stall)
        else $error("input open right after a transfer");

    // Outstanding never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.outstanding <= 6'(TABLE_DEPTH))
        else $error("outstanding above table depth");

    // A full-table report only comes with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_TABLE_FULL |->
        result.outstanding == 6'(TABLE_DEPTH))
        else $error("table_full with free slots");
endmodule

bind ack_retransmit_tracker_top art_checker u_art_checker (.*);
